// File: sv/vss_pkg.sv
`timescale 1ns / 1ps
package vss_pkg;

  localparam int Q_W = 32;
  localparam int FRAC_W = 16;
  localparam int DEF_MAX_ORDER = 16;
  localparam int INDEX_W = 6;
  localparam int DIV_W = Q_W + FRAC_W;
  localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [Q_W-1:0] node_value;
    logic signed [Q_W-1:0] rhs_value;
    logic                  last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] weight_value;
    logic [INDEX_W-1:0]    weight_index;
    logic                  last_weight;
    logic                  divide_error;
    logic                  overflow_seen;
  } out_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] v;
    logic                  ovf;
  } sat_t;

  typedef struct packed {
    logic                  done;
    logic                  err;
    logic                  ovf;
    logic signed [Q_W-1:0] value;
  } div_stat_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_SETUP,
    S_SINGLE,
    S_NEG0,
    S_BI,
    S_BX,
    S_BJ,
    S_BM,
    S_BW,
    S_BL,
    S_BL2,
    S_EI,
    S_EX,
    S_EM1,
    S_EM2,
    S_EM3,
    S_EM4,
    S_EM5,
    S_DV,
    S_DW,
    S_OUT
  } state_t;

  function automatic sat_t sat_add(input logic signed [Q_W-1:0] a,
                                   input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    sat_t r;
    s = (Q_W+1)'(a) + (Q_W+1)'(b);
    r.ovf = s[Q_W] ^ s[Q_W-1];
    if (r.ovf) begin
      r.v = s[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r.v = s[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic sat_t sat_neg(input logic signed [Q_W-1:0] a);
    sat_t r;
    r.ovf = (a == Q_MIN);
    r.v = r.ovf ? Q_MAX : -a;
    return r;
  endfunction

endpackage

// File: sv/vss_mul.sv
`timescale 1ns / 1ps
module vss_mul (
  input  logic                        clk,
  input  logic signed [vss_pkg::Q_W-1:0] a,
  input  logic signed [vss_pkg::Q_W-1:0] b,
  output vss_pkg::sat_t               res
);
  import vss_pkg::*;

  logic signed [2*Q_W-1:0] prod;
  logic signed [2*Q_W-1:0] rnd;

  always_ff @(posedge clk) begin
    prod <= (2*Q_W)'(a) * (2*Q_W)'(b);
  end

  // round half up, then floor shift; fits when the top bits all agree
  always_comb begin
    rnd = prod + (2*Q_W)'(64'sd32768);
    res.ovf = !((&rnd[2*Q_W-1:Q_W+FRAC_W-1]) || !(|rnd[2*Q_W-1:Q_W+FRAC_W-1]));
    if (res.ovf) begin
      res.v = rnd[2*Q_W-1] ? Q_MIN : Q_MAX;
    end else begin
      res.v = rnd[Q_W+FRAC_W-1:FRAC_W];
    end
  end

endmodule

// File: sv/vss_div.sv
`timescale 1ns / 1ps
module vss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [vss_pkg::Q_W-1:0] num,
  input  logic signed [vss_pkg::Q_W-1:0] den,
  output vss_pkg::div_stat_t          stat
);
  import vss_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [Q_W:0]     rem;
  logic [DIV_W-1:0] qd;
  logic [Q_W-1:0]   dmag;
  logic             neg;
  logic             num_neg;
  logic             zero_den;
  logic [Q_W:0]     rem_sh;
  logic [Q_W+1:0]   diff;
  logic [Q_W-1:0]   nmag;

  always_comb begin
    nmag = num[Q_W-1] ? Q_W'(-num) : Q_W'(num);
    rem_sh = {rem[Q_W-1:0], qd[DIV_W-1]};
    diff = {1'b0, rem_sh} - {2'b00, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      qd <= {nmag, FRAC_W'(0)};
      rem <= '0;
      cnt <= '0;
      dmag <= den[Q_W-1] ? Q_W'(-den) : Q_W'(den);
      neg <= num[Q_W-1] ^ den[Q_W-1];
      num_neg <= num[Q_W-1];
      zero_den <= (den == '0);
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (!diff[Q_W+1]) begin
        rem <= diff[Q_W:0];
        qd <= {qd[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        qd <= {qd[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    stat.done = done;
    stat.err = zero_den;
    if (zero_den) begin
      stat.ovf = 1'b1;
      stat.value = num_neg ? Q_MIN : Q_MAX;
    end else if (neg) begin
      stat.ovf = (qd > DIV_W'(48'h0000_8000_0000));
      stat.value = stat.ovf ? Q_MIN : Q_W'(-qd[Q_W-1:0]);
    end else begin
      stat.ovf = (qd > DIV_W'(48'h0000_7FFF_FFFF));
      stat.value = stat.ovf ? Q_MAX : qd[Q_W-1:0];
    end
  end

endmodule

// File: sv/vandermonde_system_solver_core.sv
`timescale 1ns / 1ps
// Vandermonde solver in signed Q16.16. Each pair item is taken in one cycle
// and stored; the item marked last_pair starts the solve over the n stored
// pairs (up to MAX_ORDER, extra pairs are dropped and flagged), and the block
// takes no pair until the last weight item has gone out. For n = 1 the
// stored rhs value is sent as the weight with no division. Otherwise the
// master polynomial is built on one shared multiplier and saturating adder,
// and each weight is then evaluated and divided in the bit-serial divider
// before its output handshake.
module vandermonde_system_solver_core #(
  parameter int MAX_ORDER = vss_pkg::DEF_MAX_ORDER
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_ready,
  input  vss_pkg::in_item_t   pair,
  output logic                weight_valid,
  input  logic                weight_ready,
  output vss_pkg::out_item_t  weight
);
  import vss_pkg::*;

  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W = $clog2(MAX_ORDER + 1);

  state_t state, state_next;

  logic signed [Q_W-1:0] node_store [MAX_ORDER];
  logic signed [Q_W-1:0] rhs_store  [MAX_ORDER];
  logic signed [Q_W-1:0] poly_coeffs [MAX_ORDER];

  logic [CNT_W-1:0] pair_count;
  logic             sticky_overflow, sticky_next;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] i, j, m;
  logic             first_j;
  logic signed [Q_W-1:0] xn, xc, bc, dn, nm, pj;

  logic [IDX_W-1:0] node_ra, rhs_ra, poly_ra, poly_rb, poly_wa;
  logic signed [Q_W-1:0] node_q, rhs_q, pa_q, pb_q, poly_wd;
  logic             poly_we;
  logic signed [Q_W-1:0] mul_a, mul_b;
  sat_t             mul_res, add_res, neg_res;
  logic             div_start;
  div_stat_t        div_stat;
  logic             full, pair_acc, weight_acc, sat_event;

  assign full = (pair_count == CNT_W'(MAX_ORDER));
  assign pair_acc = pair_valid && pair_ready;
  assign weight_acc = weight_valid && weight_ready;

  vss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mul_res)
  );

  vss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nm),
    .den   (dn),
    .stat  (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (pair_acc && pair.last_pair) state_next = S_SETUP;
      S_SETUP:  state_next = (n == CNT_W'(1)) ? S_SINGLE : S_NEG0;
      S_SINGLE: state_next = S_OUT;
      S_NEG0:   state_next = S_BI;
      S_BI:     state_next = S_BX;
      S_BX:     state_next = S_BJ;
      S_BJ:     state_next = S_BM;
      S_BM:     state_next = S_BW;
      S_BW: begin
        if ((CNT_W'(j) + CNT_W'(1)) < (n - CNT_W'(1))) state_next = S_BJ;
        else state_next = S_BL;
      end
      S_BL:     state_next = S_BL2;
      S_BL2: begin
        if ((CNT_W'(i) + CNT_W'(1)) < n) state_next = S_BI;
        else state_next = S_EI;
      end
      S_EI:     state_next = S_EX;
      S_EX:     state_next = S_EM1;
      S_EM1:    state_next = S_EM2;
      S_EM2:    state_next = S_EM3;
      S_EM3:    state_next = S_EM4;
      S_EM4:    state_next = S_EM5;
      S_EM5:    state_next = (m != IDX_W'(1)) ? S_EM1 : S_DV;
      S_DV:     state_next = S_DW;
      S_DW:     if (div_stat.done) state_next = S_OUT;
      S_OUT: begin
        if (weight_acc) state_next = weight.last_weight ? S_LOAD : S_EI;
      end
      default:  state_next = S_LOAD;
    endcase
  end

  // control outputs, addresses and unit operands
  always_comb begin
    pair_ready = (state == S_LOAD);
    weight_valid = (state == S_OUT);
    div_start = (state == S_DV);
    node_ra = '0;
    rhs_ra = '0;
    poly_ra = '0;
    poly_rb = '0;
    poly_we = 1'b0;
    poly_wa = '0;
    mul_a = xc;
    mul_b = bc;
    add_res = sat_add(pj, mul_res.v);
    neg_res = sat_neg(node_q);
    poly_wd = add_res.v;
    sat_event = 1'b0;
    case (state)
      S_LOAD: sat_event = pair_acc && full;
      S_SETUP: begin
        node_ra = '0;
        rhs_ra = '0;
      end
      S_NEG0: begin
        poly_we = 1'b1;
        poly_wa = IDX_W'(n - CNT_W'(1));
        poly_wd = neg_res.v;
        sat_event = neg_res.ovf;
      end
      S_BI: node_ra = i;
      S_BX: sat_event = neg_res.ovf;
      S_BJ: begin
        poly_ra = j;
        poly_rb = IDX_W'(CNT_W'(j) + CNT_W'(1));
      end
      S_BM: begin
        mul_a = xn;
        mul_b = pb_q;
      end
      S_BW: begin
        poly_we = 1'b1;
        poly_wa = j;
        sat_event = mul_res.ovf || add_res.ovf;
      end
      S_BL: poly_rb = IDX_W'(n - CNT_W'(1));
      S_BL2: begin
        add_res = sat_add(pb_q, xn);
        poly_wd = add_res.v;
        poly_we = 1'b1;
        poly_wa = IDX_W'(n - CNT_W'(1));
        sat_event = add_res.ovf;
      end
      S_EI: begin
        node_ra = i;
        rhs_ra = IDX_W'(n - CNT_W'(1));
      end
      S_EM1: poly_rb = m;
      S_EM2: begin
        rhs_ra = m - IDX_W'(1);
        add_res = sat_add(pb_q, mul_res.v);
        sat_event = mul_res.ovf || add_res.ovf;
      end
      S_EM3: begin
        mul_a = rhs_q;
        mul_b = bc;
      end
      S_EM4: begin
        mul_a = xc;
        mul_b = dn;
        add_res = sat_add(nm, mul_res.v);
        sat_event = mul_res.ovf || add_res.ovf;
      end
      S_EM5: begin
        add_res = sat_add(mul_res.v, bc);
        sat_event = mul_res.ovf || add_res.ovf;
      end
      S_DW: sat_event = div_stat.done && div_stat.ovf;
      default: ;
    endcase
    sticky_next = sticky_overflow || sat_event;
    if (weight_acc && weight.last_weight) sticky_next = 1'b0;
  end

  // stores and registered reads
  always_ff @(posedge clk) begin
    if (pair_acc && !full) begin
      node_store[IDX_W'(pair_count)] <= pair.node_value;
      rhs_store[IDX_W'(pair_count)] <= pair.rhs_value;
    end
    if (poly_we) poly_coeffs[poly_wa] <= poly_wd;
    node_q <= node_store[node_ra];
    rhs_q <= rhs_store[rhs_ra];
    pa_q <= poly_coeffs[poly_ra];
    pb_q <= poly_coeffs[poly_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      pair_count <= '0;
      sticky_overflow <= 1'b0;
    end else begin
      state <= state_next;
      sticky_overflow <= sticky_next;
      if (pair_acc && !full) pair_count <= pair_count + CNT_W'(1);
      else if (weight_acc && weight.last_weight) pair_count <= '0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: if (pair_acc) n <= full ? pair_count : pair_count + CNT_W'(1);
      S_SETUP: i <= IDX_W'(1);
      S_SINGLE: begin
        weight.weight_value <= rhs_q;
        weight.weight_index <= '0;
        weight.last_weight <= 1'b1;
        weight.divide_error <= 1'b0;
        weight.overflow_seen <= sticky_overflow;
      end
      S_BX: begin
        xn <= neg_res.v;
        j <= IDX_W'(n - CNT_W'(1) - CNT_W'(i));
        first_j <= 1'b1;
      end
      S_BM: begin
        // the lowest touched coefficient is still zero on this pass
        pj <= first_j ? '0 : pa_q;
      end
      S_BW: begin
        first_j <= 1'b0;
        j <= j + IDX_W'(1);
      end
      S_BL2: begin
        if ((CNT_W'(i) + CNT_W'(1)) < n) i <= i + IDX_W'(1);
        else i <= '0;
      end
      S_EX: begin
        xc <= node_q;
        bc <= Q_ONE;
        dn <= Q_ONE;
        nm <= rhs_q;
        m <= IDX_W'(n - CNT_W'(1));
      end
      S_EM2: bc <= add_res.v;
      S_EM4: nm <= add_res.v;
      S_EM5: begin
        dn <= add_res.v;
        m <= m - IDX_W'(1);
      end
      S_DW: begin
        if (div_stat.done) begin
          weight.weight_value <= div_stat.value;
          weight.weight_index <= INDEX_W'(i);
          weight.last_weight <= ((CNT_W'(i) + CNT_W'(1)) == n);
          weight.divide_error <= div_stat.err;
          weight.overflow_seen <= sticky_overflow || div_stat.ovf;
        end
      end
      S_OUT: if (weight_acc) i <= i + IDX_W'(1);
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    !(pair_ready && weight_valid))
    else $error("pair accepted while a weight item waits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= CNT_W'(MAX_ORDER))
    else $error("pair count beyond store depth");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (weight_acc && weight.last_weight) |=> (pair_count == '0 && !sticky_overflow))
    else $error("run state not cleared after final weight");

  a_index_in_run: assert property (@(posedge clk) disable iff (rst)
    weight_valid |-> (CNT_W'(weight.weight_index) < n))
    else $error("weight index outside run");

  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DW))
    else $error("divider finished outside its wait state");
`endif

endmodule
